>>> sv/i2r_pkg.sv
// Shared types, constants and decode functions for the integer to Roman numeral encoder.
package i2r_pkg;

  localparam int unsigned MaxThousands = 3;
  localparam int unsigned ValueW       = 12;
  localparam int unsigned InDataW      = 16;
  localparam int unsigned SymW         = 8;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned WeightW      = 14;
  localparam int unsigned MaxResults   = 15;
  localparam int unsigned CntW         = 4;
  localparam int unsigned NumDecades   = 4;
  localparam int unsigned FifoDepth    = 2;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);
  localparam int unsigned FifoCntW     = $clog2(FifoDepth + 1);

  localparam logic [SymW-1:0] SymM = 8'd77;
  localparam logic [SymW-1:0] SymD = 8'd68;
  localparam logic [SymW-1:0] SymC = 8'd67;
  localparam logic [SymW-1:0] SymL = 8'd76;
  localparam logic [SymW-1:0] SymX = 8'd88;
  localparam logic [SymW-1:0] SymV = 8'd86;
  localparam logic [SymW-1:0] SymI = 8'd73;

  typedef enum logic [1:0] {
    DecThou,
    DecHund,
    DecTens,
    DecUnits
  } decade_e;

  typedef enum logic [1:0] {
    FrIdle,
    FrSplit,
    FrPush
  } front_state_e;

  // One value split into decimal digits; the thousands count is already saturated.
  typedef struct packed {
    logic [DigitW-1:0] thou;
    logic [DigitW-1:0] hund;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] units;
  } desc_t;

  // Weight of digit k in the given decade.
  function automatic logic [WeightW-1:0] step_weight(decade_e dec, logic [DigitW-1:0] k);
    logic [WeightW-1:0] base;
    unique case (dec)
      DecThou:  base = 14'd1000;
      DecHund:  base = 14'd100;
      DecTens:  base = 14'd10;
      DecUnits: base = 14'd1;
      default:  base = 14'd0;
    endcase
    return WeightW'({10'd0, k} * base);
  endfunction

  // Number of letters a hundreds, tens or units digit produces.
  function automatic logic [DigitW-1:0] digit_len(logic [DigitW-1:0] d);
    logic [DigitW-1:0] len;
    unique case (d) inside
      4'd1, 4'd2, 4'd3:       len = d;
      4'd4, 4'd9:             len = 4'd2;
      4'd5, 4'd6, 4'd7, 4'd8: len = d - 4'd4;
      default:                len = 4'd0;
    endcase
    return len;
  endfunction

  // Letter at position pos of the numeral for digit d in decade dec.
  function automatic logic [SymW-1:0] digit_letter(decade_e dec, logic [DigitW-1:0] d,
                                                   logic [DigitW-1:0] pos);
    logic [SymW-1:0] one;
    logic [SymW-1:0] five;
    logic [SymW-1:0] ten;
    logic [SymW-1:0] sym;
    unique case (dec)
      DecHund: begin
        one = SymC; five = SymD; ten = SymM;
      end
      DecTens: begin
        one = SymX; five = SymL; ten = SymC;
      end
      DecUnits: begin
        one = SymI; five = SymV; ten = SymX;
      end
      default: begin
        one = SymM; five = SymM; ten = SymM;
      end
    endcase
    if (dec == DecThou) begin
      sym = SymM;
    end else if (d == 4'd9) begin
      sym = (pos == 4'd0) ? one : ten;
    end else if (d == 4'd4) begin
      sym = (pos == 4'd0) ? one : five;
    end else if (d >= 4'd5) begin
      sym = (pos == 4'd0) ? five : one;
    end else begin
      sym = one;
    end
    return sym;
  endfunction

endpackage

>>> sv/i2r_front.sv
// Front end: accepts a value and splits it into saturated thousands and three decimal digits.
module i2r_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [i2r_pkg::InDataW-1:0] s_axis_tdata,  // [11:0] value, [15:12] zero
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output i2r_pkg::desc_t              push_data_o
);

  i2r_pkg::front_state_e              state_q, state_d;
  i2r_pkg::decade_e                   dec_q, dec_d;
  logic [i2r_pkg::ValueW-1:0]         rem_q, rem_d;
  i2r_pkg::desc_t                     desc_q, desc_d;
  logic                               zero_q, zero_d;
  logic [i2r_pkg::DigitW-1:0]         digit;
  logic [i2r_pkg::DigitW-1:0]         thou_sat;

  // The compares against k times the decade weight form a thermometer; the top set bit is the digit.
  always_comb begin
    digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem_q} >= i2r_pkg::step_weight(dec_q, i2r_pkg::DigitW'(k))) begin
        digit = i2r_pkg::DigitW'(k);
      end
    end
    thou_sat = (digit > i2r_pkg::DigitW'(i2r_pkg::MaxThousands)) ?
               i2r_pkg::DigitW'(i2r_pkg::MaxThousands) : digit;
  end

  always_comb begin
    state_d       = state_q;
    dec_d         = dec_q;
    rem_d         = rem_q;
    desc_d        = desc_q;
    zero_d        = zero_q;
    s_axis_tready = 1'b0;
    push_valid_o  = 1'b0;
    unique case (state_q)
      i2r_pkg::FrIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          rem_d   = s_axis_tdata[i2r_pkg::ValueW-1:0];
          zero_d  = (s_axis_tdata[i2r_pkg::ValueW-1:0] == '0);
          dec_d   = i2r_pkg::DecThou;
          state_d = i2r_pkg::FrSplit;
        end
      end
      i2r_pkg::FrSplit: begin
        rem_d = i2r_pkg::ValueW'({2'b00, rem_q} - i2r_pkg::step_weight(dec_q, digit));
        unique case (dec_q)
          i2r_pkg::DecThou:  desc_d.thou  = thou_sat;
          i2r_pkg::DecHund:  desc_d.hund  = digit;
          i2r_pkg::DecTens:  desc_d.tens  = digit;
          i2r_pkg::DecUnits: desc_d.units = digit;
          default:           desc_d.units = digit;
        endcase
        if (dec_q == i2r_pkg::DecUnits) begin
          state_d = i2r_pkg::FrPush;
        end else begin
          dec_d = i2r_pkg::decade_e'(dec_q + 2'd1);
        end
      end
      i2r_pkg::FrPush: begin
        // A zero value has an empty numeral and is dropped here.
        push_valid_o = !zero_q;
        if (zero_q || push_ready_i) begin
          state_d = i2r_pkg::FrIdle;
        end
      end
      default: state_d = i2r_pkg::FrIdle;
    endcase
  end

  assign push_data_o = desc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2r_pkg::FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q  <= dec_d;
    rem_q  <= rem_d;
    desc_q <= desc_d;
    zero_q <= zero_d;
  end

endmodule

>>> sv/i2r_fifo.sv
// Short descriptor queue between the front end and the letter sequencer.
module i2r_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  i2r_pkg::desc_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output i2r_pkg::desc_t pop_data_o
);

  i2r_pkg::desc_t                  mem_q [i2r_pkg::FifoDepth];
  logic [i2r_pkg::FifoPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [i2r_pkg::FifoCntW-1:0]    cnt_q;
  logic                            do_push, do_pop;

  assign push_ready_o = (cnt_q != i2r_pkg::FifoCntW'(i2r_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == i2r_pkg::FifoPtrW'(i2r_pkg::FifoDepth - 1)) ? '0 :
                    wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == i2r_pkg::FifoPtrW'(i2r_pkg::FifoDepth - 1)) ? '0 :
                    rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/i2r_back.sv
// Back end: emits a descriptor's numeral, one letter per cycle in a digit unless stalled.
module i2r_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_ready_o,
  input  i2r_pkg::desc_t           pop_data_i,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [i2r_pkg::SymW-1:0] m_axis_tdata,  // [7:0] symbol
  output logic                     m_axis_tlast   // last
);

  logic                          busy_q, busy_d;
  logic [i2r_pkg::DigitW-1:0]    dig_q [i2r_pkg::NumDecades];
  logic [i2r_pkg::DigitW-1:0]    dig_d [i2r_pkg::NumDecades];
  i2r_pkg::decade_e              idx_q, idx_d;
  logic [i2r_pkg::DigitW-1:0]    pos_q, pos_d;
  logic [i2r_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic [i2r_pkg::SymW-1:0]      out_sym_q, out_sym_d;
  logic                          out_last_q, out_last_d;
  logic [i2r_pkg::DigitW-1:0]    lens [i2r_pkg::NumDecades];
  logic                          has_letter;
  logic                          rest_empty;
  logic                          is_last;
  logic                          take;

  always_comb begin
    lens[0] = dig_q[0];
    for (int j = 1; j < i2r_pkg::NumDecades; j++) begin
      lens[j] = i2r_pkg::digit_len(dig_q[j]);
    end
    rest_empty = 1'b1;
    for (int j = 0; j < i2r_pkg::NumDecades; j++) begin
      if ((2'(j) > idx_q) && (lens[j] != '0)) begin
        rest_empty = 1'b0;
      end
    end
  end

  assign has_letter = busy_q && (pos_q < lens[idx_q]);
  // The run also closes when it reaches the letter limit.
  assign is_last    = ((pos_q == lens[idx_q] - 4'd1) && rest_empty) ||
                      (cnt_q == i2r_pkg::CntW'(i2r_pkg::MaxResults - 1));
  assign take       = !out_valid_q || m_axis_tready;
  assign pop_ready_o = !busy_q;

  always_comb begin
    busy_d      = busy_q;
    dig_d       = dig_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (!busy_q) begin
      if (pop_valid_i) begin
        dig_d[0] = pop_data_i.thou;
        dig_d[1] = pop_data_i.hund;
        dig_d[2] = pop_data_i.tens;
        dig_d[3] = pop_data_i.units;
        idx_d    = i2r_pkg::DecThou;
        pos_d    = '0;
        cnt_d    = '0;
        busy_d   = 1'b1;
      end
    end else if (has_letter) begin
      if (take) begin
        out_valid_d = 1'b1;
        out_sym_d   = i2r_pkg::digit_letter(idx_q, dig_q[idx_q], pos_q);
        out_last_d  = is_last;
        pos_d       = pos_q + 4'd1;
        cnt_d       = cnt_q + 4'd1;
        if (is_last) begin
          busy_d = 1'b0;
        end
      end
    end else if (idx_q == i2r_pkg::DecUnits) begin
      busy_d = 1'b0;
    end else begin
      idx_d = i2r_pkg::decade_e'(idx_q + 2'd1);
      pos_d = '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sym_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q      <= dig_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

endmodule

>>> sv/integer_to_roman_encoder_top.sv
// Top level of the integer to Roman numeral encoder.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[11:0] value
//   m_axis   out        tdata[7:0] symbol (ASCII), tlast on the final letter
//
// The front end takes one transaction, then splits it into digits one decade at a time
// and hands it to a two-entry queue; it takes no new value until that hand-off is done.
// The back end emits one letter per cycle while the output is not stalled, and it also
// steps past each digit ahead of the one holding the final letter and fetches the next
// entry; for long numerals this letter loop sets the rate.
// A zero value produces no transaction. Reset is asynchronous and active low.
// Either side may stall freely; the queue and the output register keep them apart.
module integer_to_roman_encoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [i2r_pkg::InDataW-1:0] s_axis_tdata,   // [11:0] value, [15:12] zero
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [i2r_pkg::SymW-1:0]    m_axis_tdata,   // [7:0] symbol
  output logic                        m_axis_tlast    // last
);

  logic           push_valid, push_ready;
  i2r_pkg::desc_t push_data;
  logic           pop_valid, pop_ready;
  i2r_pkg::desc_t pop_data;

  i2r_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  i2r_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  i2r_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the integer to Roman numeral encoder: predicted letters vs stream.
module tb;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned RandomValues = 105;

  typedef struct packed {
    logic [i2r_pkg::SymW-1:0] symbol;
    logic                     last;
  } letter_t;

  // Keeps the letters still owed by the encoder, oldest first.
  class roman_scoreboard;
    letter_t     owed_letters[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned owed_count();
      return owed_letters.size();
    endfunction

    // Adds one letter at the tail of a letter queue.
    function void append_letter(ref letter_t q[$], input letter_t item);
      q.insert(q.size(), item);
    endfunction

    // Works out the numeral of one accepted value and queues its letters.
    function void note_value(logic [i2r_pkg::ValueW-1:0] value);
      int unsigned              thousands;
      int unsigned              rest;
      int unsigned              digit;
      int unsigned              base;
      int                       dec;
      logic [i2r_pkg::SymW-1:0] one_letter;
      logic [i2r_pkg::SymW-1:0] five_letter;
      logic [i2r_pkg::SymW-1:0] ten_letter;
      letter_t                  numeral[$];
      thousands = value / 1000;
      rest      = value % 1000;
      if (thousands > i2r_pkg::MaxThousands) begin
        thousands = i2r_pkg::MaxThousands;
      end
      repeat (thousands) append_letter(numeral, '{i2r_pkg::SymM, 1'b0});
      for (dec = 0; dec < 3; dec++) begin
        case (dec)
          0: begin
            base = 100;
            one_letter = i2r_pkg::SymC; five_letter = i2r_pkg::SymD; ten_letter = i2r_pkg::SymM;
          end
          1: begin
            base = 10;
            one_letter = i2r_pkg::SymX; five_letter = i2r_pkg::SymL; ten_letter = i2r_pkg::SymC;
          end
          default: begin
            base = 1;
            one_letter = i2r_pkg::SymI; five_letter = i2r_pkg::SymV; ten_letter = i2r_pkg::SymX;
          end
        endcase
        digit = (rest / base) % 10;
        if (digit == 9) begin
          append_letter(numeral, '{one_letter, 1'b0});
          append_letter(numeral, '{ten_letter, 1'b0});
        end else if (digit == 4) begin
          append_letter(numeral, '{one_letter, 1'b0});
          append_letter(numeral, '{five_letter, 1'b0});
        end else begin
          if (digit >= 5) begin
            append_letter(numeral, '{five_letter, 1'b0});
            digit = digit - 5;
          end
          repeat (digit) append_letter(numeral, '{one_letter, 1'b0});
        end
      end
      // A zero value owes nothing at all.
      if (numeral.size() > 0) begin
        numeral[numeral.size() - 1].last = 1'b1;
      end
      foreach (numeral[k]) append_letter(owed_letters, numeral[k]);
    endfunction

    task report(input string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_letter(input logic [i2r_pkg::SymW-1:0] symbol, input logic last);
      letter_t owed;
      if (owed_letters.size() == 0) begin
        report($sformatf("letter 0x%02h last %0b arrived with none owed", symbol, last));
      end else begin
        owed = owed_letters.pop_front();
        if (symbol !== owed.symbol) begin
          report($sformatf("symbol 0x%02h, wanted 0x%02h", symbol, owed.symbol));
        end
        if (last !== owed.last) begin
          report($sformatf("last %0b on symbol 0x%02h, wanted %0b", last, symbol, owed.last));
        end
      end
    endtask
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [i2r_pkg::InDataW-1:0] s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [i2r_pkg::SymW-1:0]    m_axis_tdata;
  logic                        m_axis_tlast;

  roman_scoreboard sb;
  int unsigned     tx_idle_pct = 36;
  int unsigned     rx_idle_pct = 60;
  int unsigned     quiet_cycles = 0;

  integer_to_roman_encoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: checks each output transaction and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_letter(m_axis_tdata, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("simulation failed");
    $finish;
  end

  // Valid is lowered only when an idle cycle is chosen, so back-to-back values keep it high.
  task automatic send_value(input logic [i2r_pkg::ValueW-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= i2r_pkg::InDataW'(value);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_value(value);
  endtask

  task automatic send_random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_value(i2r_pkg::ValueW'($urandom_range(4095)));
    end else if (pick < 75) begin
      // Long numerals and saturated thousands.
      send_value(i2r_pkg::ValueW'($urandom_range(4095, 2800)));
    end else begin
      send_value(i2r_pkg::ValueW'($urandom_range(99)));
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes, every digit shape, saturation of the thousands and the empty numeral.
    send_value(12'd0);
    send_value(12'd1);
    send_value(12'd4);
    send_value(12'd5);
    send_value(12'd9);
    send_value(12'd14);
    send_value(12'd40);
    send_value(12'd90);
    send_value(12'd400);
    send_value(12'd900);
    send_value(12'd444);
    send_value(12'd999);
    send_value(12'd494);
    send_value(12'd949);
    send_value(12'd1000);
    send_value(12'd2000);
    send_value(12'd3000);
    send_value(12'd3888);
    send_value(12'd3999);
    send_value(12'd4000);
    send_value(12'd4095);
    send_value(12'd2048);
    send_value(12'd1234);
    send_value(12'd0);
    send_value(12'd3);

    for (int n = 0; n < RandomValues; n++) begin
      if (n == RandomValues / 3) begin
        tx_idle_pct = 60;
        rx_idle_pct = 36;
      end else if (n == 2 * RandomValues / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random_value();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.owed_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
